// File: rtl/ppr_pkg.sv
// Shared types, sizes and codes for the path point ring buffer.
// Depends on nothing; every other rtl file but ppr_ram imports it.
package ppr_pkg;

	// Store depth and derived widths
	localparam int DEPTH  = 256;
	localparam int WORD_W = 32;
	localparam int ITEM_W = 8;
	localparam int FILL_W = 8;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int ARG_W  = (IDX_W > ITEM_W) ? IDX_W : ITEM_W;
	localparam int SUM_W  = ARG_W + 1;
	localparam int PT_W   = 6 * WORD_W;

	// Action codes
	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_READ   = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_DROP   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} ppr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       append;
		logic       read;
		logic       update;
		logic       drop;
		logic       clear;
		logic [1:0] code;
	} ppr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic room;
		logic offset_ok;
	} ppr_stat_t;

	// Ring index wrap: input is known to be below twice the depth
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = s;
		if (s >= SUM_W'(DEPTH)) begin
			r = s - SUM_W'(DEPTH);
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

// File: rtl/path_point_ring_buffer.sv
// Path point ring buffer, top level. Depends on ppr_pkg, ppr_ctrl, ppr_datapath.
// The result word is strobed on done in the cycle after start is taken.
// Throughput: one word per cycle; each action is at most one access per RAM and
// one pointer update, so busy stays low and a new start may come in the done cycle.
// Reset clears head, tail and count; RAM contents are undefined until written.
// No clearing pass runs, and the receiver cannot stall the result.
module path_point_ring_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  action,
	input  logic [ppr_pkg::ITEM_W-1:0]  item_number,
	input  logic [ppr_pkg::WORD_W-1:0]  point_x,
	input  logic [ppr_pkg::WORD_W-1:0]  point_y,
	input  logic [ppr_pkg::WORD_W-1:0]  heading,
	input  logic [ppr_pkg::WORD_W-1:0]  pose_angle,
	input  logic [ppr_pkg::WORD_W-1:0]  path_length,
	input  logic [ppr_pkg::WORD_W-1:0]  curve_radius,
	input  logic [ppr_pkg::WORD_W-1:0]  max_speed,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ppr_pkg::FILL_W-1:0]  fill_count,
	output logic [ppr_pkg::WORD_W-1:0]  out_x,
	output logic [ppr_pkg::WORD_W-1:0]  out_y,
	output logic [ppr_pkg::WORD_W-1:0]  out_heading,
	output logic [ppr_pkg::WORD_W-1:0]  out_pose_angle,
	output logic [ppr_pkg::WORD_W-1:0]  out_length,
	output logic [ppr_pkg::WORD_W-1:0]  out_radius,
	output logic [ppr_pkg::WORD_W-1:0]  out_speed
);
	import ppr_pkg::*;

	ppr_cmd_t  cmd;
	ppr_stat_t stat;

	ppr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ppr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.item_number    (item_number),
		.point_x        (point_x),
		.point_y        (point_y),
		.heading        (heading),
		.pose_angle     (pose_angle),
		.path_length    (path_length),
		.curve_radius   (curve_radius),
		.max_speed      (max_speed),
		.stat           (stat),
		.status         (status),
		.fill_count     (fill_count),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_heading    (out_heading),
		.out_pose_angle (out_pose_angle),
		.out_length     (out_length),
		.out_radius     (out_radius),
		.out_speed      (out_speed)
	);

	// Every accepted word yields exactly one strobe on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted word without result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without accepted word");

	// Full refusal only on append
	a_full_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> ($past(action) == ACT_APPEND))
		else $error("full status on non-append");

	// Range error only on read or update
	a_range_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |->
		($past(action) == ACT_READ || $past(action) == ACT_UPDATE))
		else $error("range status on wrong action");

	// Words are zero unless a good read was issued
	a_zero_words: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(cmd.read)) |-> (out_x == '0 && out_speed == '0))
		else $error("nonzero words without a read");

endmodule

// File: rtl/ppr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module ppr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ppr_ctrl.sv
// Controller: decodes the action, picks the status code, sequences the strobe.
// Depends on ppr_pkg.
module ppr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         action,
	input  ppr_pkg::ppr_stat_t stat,
	output ppr_pkg::ppr_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import ppr_pkg::*;

	ppr_state_t state_q, state_d;
	logic       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		cmd.code = ST_OK;
		state_d  = accept ? S_RESULT : S_IDLE;
		done     = (state_q == S_RESULT);
		unique case (action)
			ACT_APPEND: begin
				cmd.append = accept && stat.room;
				cmd.code   = stat.room ? ST_OK : ST_FULL;
			end
			ACT_READ: begin
				cmd.read = accept && stat.offset_ok;
				cmd.code = stat.offset_ok ? ST_OK : ST_RANGE;
			end
			ACT_UPDATE: begin
				cmd.update = accept && stat.offset_ok;
				cmd.code   = stat.offset_ok ? ST_OK : ST_RANGE;
			end
			ACT_DROP: begin
				cmd.drop = accept;
			end
			ACT_CLEAR: begin
				cmd.clear = accept;
			end
			default: begin
				cmd.code = ST_OK;
			end
		endcase
	end

endmodule

// File: rtl/ppr_datapath.sv
// Datapath: ring pointers, fill count, point and speed RAMs, result registers.
// Depends on ppr_pkg and ppr_ram.
module ppr_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppr_pkg::ppr_cmd_t           cmd,
	input  logic [ppr_pkg::ITEM_W-1:0]  item_number,
	input  logic [ppr_pkg::WORD_W-1:0]  point_x,
	input  logic [ppr_pkg::WORD_W-1:0]  point_y,
	input  logic [ppr_pkg::WORD_W-1:0]  heading,
	input  logic [ppr_pkg::WORD_W-1:0]  pose_angle,
	input  logic [ppr_pkg::WORD_W-1:0]  path_length,
	input  logic [ppr_pkg::WORD_W-1:0]  curve_radius,
	input  logic [ppr_pkg::WORD_W-1:0]  max_speed,
	output ppr_pkg::ppr_stat_t          stat,
	output logic [1:0]                  status,
	output logic [ppr_pkg::FILL_W-1:0]  fill_count,
	output logic [ppr_pkg::WORD_W-1:0]  out_x,
	output logic [ppr_pkg::WORD_W-1:0]  out_y,
	output logic [ppr_pkg::WORD_W-1:0]  out_heading,
	output logic [ppr_pkg::WORD_W-1:0]  out_pose_angle,
	output logic [ppr_pkg::WORD_W-1:0]  out_length,
	output logic [ppr_pkg::WORD_W-1:0]  out_radius,
	output logic [ppr_pkg::WORD_W-1:0]  out_speed
);
	import ppr_pkg::*;

	logic [IDX_W-1:0]  head_q, tail_q, count_q;
	logic [1:0]        status_q;
	logic              read_ok_q;
	logic [SUM_W-1:0]  k_ext, cnt_ext, head_ext, k_sat;
	logic [IDX_W-1:0]  rd_idx, drop_head, tail_next, spd_waddr;
	logic [PT_W-1:0]   pt_wdata, pt_rdata;
	logic [WORD_W-1:0] spd_rdata;

	// Range checks and ring address arithmetic
	always_comb begin
		k_ext          = SUM_W'(item_number);
		cnt_ext        = SUM_W'(count_q);
		head_ext       = SUM_W'(head_q);
		stat.room      = cnt_ext < SUM_W'(DEPTH - 2);
		stat.offset_ok = (k_ext != '0) && (k_ext <= cnt_ext);
		k_sat          = (k_ext > cnt_ext) ? cnt_ext : k_ext;
		rd_idx         = wrap_idx(head_ext + k_ext - SUM_W'(1));
		drop_head      = wrap_idx(head_ext + k_sat);
		tail_next      = wrap_idx(SUM_W'(tail_q) + SUM_W'(1));
		spd_waddr      = cmd.append ? tail_q : rd_idx;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			priority if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.append) begin
				tail_q  <= tail_next;
				count_q <= count_q + IDX_W'(1);
			end else if (cmd.drop) begin
				head_q  <= drop_head;
				count_q <= count_q - k_sat[IDX_W-1:0];
			end
		end
	end

	// Result status and read qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= ST_OK;
			read_ok_q <= 1'b0;
		end else if (cmd.load) begin
			status_q  <= cmd.code;
			read_ok_q <= cmd.read;
		end
	end

	assign pt_wdata = {curve_radius, path_length, pose_angle, heading, point_y, point_x};

	// Six point words share one RAM; speed has its own for updates
	ppr_ram #(.WIDTH(PT_W), .DEPTH(DEPTH)) u_pt_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (tail_q),
		.wdata (pt_wdata),
		.re    (cmd.read),
		.raddr (rd_idx),
		.rdata (pt_rdata)
	);

	ppr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_spd_ram (
		.clk   (clk),
		.we    (cmd.append || cmd.update),
		.waddr (spd_waddr),
		.wdata (max_speed),
		.re    (cmd.read),
		.raddr (rd_idx),
		.rdata (spd_rdata)
	);

	// Result words, zero unless a good read
	assign status         = status_q;
	assign fill_count     = FILL_W'(cnt_ext);
	assign out_x          = read_ok_q ? pt_rdata[0*WORD_W +: WORD_W] : '0;
	assign out_y          = read_ok_q ? pt_rdata[1*WORD_W +: WORD_W] : '0;
	assign out_heading    = read_ok_q ? pt_rdata[2*WORD_W +: WORD_W] : '0;
	assign out_pose_angle = read_ok_q ? pt_rdata[3*WORD_W +: WORD_W] : '0;
	assign out_length     = read_ok_q ? pt_rdata[4*WORD_W +: WORD_W] : '0;
	assign out_radius     = read_ok_q ? pt_rdata[5*WORD_W +: WORD_W] : '0;
	assign out_speed      = read_ok_q ? spd_rdata : '0;

endmodule
